[design/annexb_pkg.sv]
// ----------------------------------------------------------------------------
// annexb_pkg
// Shared types and constants of the Annex-B NAL unit splitter.
// ----------------------------------------------------------------------------
package annexb_pkg;

    localparam int MAX_UNIT_BYTES = 1048576;
    localparam int CNT_W          = 21;
    localparam int CNT_FIELD_MAX  = (1 << CNT_W) - 1;
    localparam int CNT_CAP_INT    = (MAX_UNIT_BYTES > CNT_FIELD_MAX) ?
                                    CNT_FIELD_MAX : MAX_UNIT_BYTES;
    localparam logic [CNT_W-1:0] CNT_CAP = CNT_W'(CNT_CAP_INT);

    localparam logic [7:0] BYTE_ZERO = 8'h00;
    localparam logic [7:0] BYTE_ONE  = 8'h01;

    localparam logic [4:0] TYPE_IDR = 5'h05;
    localparam logic [4:0] TYPE_SPS = 5'h07;
    localparam logic [4:0] TYPE_PPS = 5'h08;

    localparam logic [1:0] PS_NONE = 2'd0;
    localparam logic [1:0] PS_SPS  = 2'd1;
    localparam logic [1:0] PS_PPS  = 2'd2;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;

    // One classified input byte: up to four zeros, then one data byte
    // (header or payload), then an end-of-unit record.
    typedef struct packed {
        logic [2:0]       nzero;
        logic             has_byte;
        logic             is_hdr;
        logic [7:0]       data;
        logic             has_end;
        logic             done;
        logic [4:0]       utype;
        logic [CNT_W-1:0] len;
    } cmd_t;

endpackage

[design/annexb_nal_unit_splitter.sv]
// ----------------------------------------------------------------------------
// annexb_nal_unit_splitter
// Splits an Annex-B byte stream into NAL unit bytes and end-of-unit records.
// ----------------------------------------------------------------------------
// A command is registered in the queue, then in the sequencer. Throughput,
// while m_tready is high: one input byte per cycle while each byte yields
// at most one result; bytes yielding up to five results drain one result
// per cycle, with a four-entry command queue absorbing the burst.
// Reset: synchronous active-low aresetn clears the detector state, queue
// and output valid; no clearing pass.
module annexb_nal_unit_splitter (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tlast,   // frame_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [7:0] out_byte, [12:8] unit_type,
                                   // [33:13] unit_length, [34] key_frame,
                                   // [36:35] param_set, [37] frame_done
    output logic [1:0]  m_tuser,   // [0] kind, [1] first_in_unit
    output logic        m_tlast    // last_result
);
    import annexb_pkg::*;

    logic q_full, q_empty, push, pop;
    cmd_t push_cmd, head_cmd;

    annexb_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_byte  (s_tdata),
        .in_last  (s_tlast),
        .q_full   (q_full),
        .in_ready (s_tready),
        .push     (push),
        .push_cmd (push_cmd)
    );

    annexb_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (push),
        .wr_data (push_cmd),
        .full    (q_full),
        .rd_en   (pop),
        .rd_data (head_cmd),
        .empty   (q_empty)
    );

    annexb_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_data   (head_cmd),
        .q_pop    (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

[design/annexb_front.sv]
// ----------------------------------------------------------------------------
// annexb_front
// Start-code detector: classifies each input byte into at most one command.
// ----------------------------------------------------------------------------
module annexb_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    input  logic [7:0]          in_byte,
    input  logic                in_last,
    input  logic                q_full,
    output logic                in_ready,
    output logic                push,
    output annexb_pkg::cmd_t    push_cmd
);
    import annexb_pkg::*;

    logic [1:0]       zr_reg, zr_next;
    logic             inside_reg, inside_next;
    logic             exph_reg, exph_next;
    logic [4:0]       type_reg, type_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic             accept;
    logic [2:0]       nz;
    logic             has_byte, is_hdr, has_end, done;
    logic [CNT_W-1:0] cnt_base, cnt_after;
    logic [2:0]       add;
    logic [CNT_W:0]   sum;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    always_comb begin
        nz          = 3'd0;
        has_byte    = 1'b0;
        is_hdr      = 1'b0;
        has_end     = 1'b0;
        done        = 1'b0;
        zr_next     = zr_reg;
        inside_next = inside_reg;
        exph_next   = exph_reg;
        type_next   = type_reg;
        cnt_base    = cnt_reg;

        if (exph_reg) begin
            type_next   = in_byte[4:0];
            cnt_base    = CNT_W'(1);
            inside_next = 1'b1;
            exph_next   = 1'b0;
            zr_next     = 2'd0;
            has_byte    = 1'b1;
            is_hdr      = 1'b1;
        end else if (in_byte == BYTE_ZERO) begin
            // a fourth zero pushes the oldest held zero out
            if (zr_reg == 2'd3) begin
                if (inside_reg) begin
                    nz = 3'd1;
                end
            end else begin
                zr_next = zr_reg + 2'd1;
            end
        end else if (in_byte == BYTE_ONE && zr_reg >= 2'd2) begin
            if (inside_reg) begin
                has_end = 1'b1;
                done    = in_last;
            end
            inside_next = 1'b0;
            exph_next   = !in_last;
            zr_next     = 2'd0;
        end else begin
            if (inside_reg) begin
                nz       = {1'b0, zr_reg};
                has_byte = 1'b1;
            end
            zr_next = 2'd0;
        end

        if (in_last) begin
            if (inside_next) begin
                nz      = nz + {1'b0, zr_next};
                has_end = 1'b1;
                done    = 1'b1;
            end
            zr_next     = 2'd0;
            inside_next = 1'b0;
            exph_next   = 1'b0;
        end

        add = nz + {2'b00, (has_byte && !is_hdr)};
        sum = {1'b0, cnt_base} + (CNT_W+1)'(add);
        if (sum > {1'b0, CNT_CAP}) begin
            cnt_after = CNT_CAP;
        end else begin
            cnt_after = sum[CNT_W-1:0];
        end
        cnt_next = in_last ? '0 : cnt_after;
    end

    assign push              = accept && (nz != 3'd0 || has_byte || has_end);
    assign push_cmd.nzero    = nz;
    assign push_cmd.has_byte = has_byte;
    assign push_cmd.is_hdr   = is_hdr;
    assign push_cmd.data     = in_byte;
    assign push_cmd.has_end  = has_end;
    assign push_cmd.done     = done;
    assign push_cmd.utype    = type_next;
    assign push_cmd.len      = cnt_after;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zr_reg     <= '0;
            inside_reg <= 1'b0;
            exph_reg   <= 1'b0;
            type_reg   <= '0;
            cnt_reg    <= '0;
        end else if (accept) begin
            zr_reg     <= zr_next;
            inside_reg <= inside_next;
            exph_reg   <= exph_next;
            type_reg   <= type_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

[design/annexb_fifo.sv]
// ----------------------------------------------------------------------------
// annexb_fifo
// Short command queue between the detector and the result sequencer.
// ----------------------------------------------------------------------------
module annexb_fifo (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                wr_en,
    input  annexb_pkg::cmd_t    wr_data,
    output logic                full,
    input  logic                rd_en,
    output annexb_pkg::cmd_t    rd_data,
    output logic                empty
);
    import annexb_pkg::*;

    cmd_t               mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wp_reg, wp_next;
    logic [FIFO_AW-1:0] rp_reg, rp_next;
    logic [FIFO_AW:0]   cnt_reg, cnt_next;
    logic               do_wr, do_rd;

    assign full    = (cnt_reg == (FIFO_AW+1)'(FIFO_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem[rp_reg];

    always_comb begin
        wp_next  = do_wr ? wp_reg + FIFO_AW'(1) : wp_reg;
        rp_next  = do_rd ? rp_reg + FIFO_AW'(1) : rp_reg;
        cnt_next = cnt_reg + (FIFO_AW+1)'(do_wr) - (FIFO_AW+1)'(do_rd);
    end

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            mem[wp_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

[design/annexb_back.sv]
// ----------------------------------------------------------------------------
// annexb_back
// Result sequencer: expands one command into its result requests.
// ----------------------------------------------------------------------------
module annexb_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_empty,
    input  annexb_pkg::cmd_t    q_data,
    output logic                q_pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [39:0]         m_tdata,
    output logic [1:0]          m_tuser,
    output logic                m_tlast
);
    import annexb_pkg::*;

    cmd_t cur_reg, cur_next;
    logic valid_reg, valid_next;

    logic             zero_ph, byte_ph, end_ph;
    logic             last_of_cmd, take;
    logic [7:0]       out_byte;
    logic [CNT_W-1:0] unit_length;
    logic             key_frame, frame_done, first_in_unit;
    logic [1:0]       param_set;

    assign zero_ph = (cur_reg.nzero != 3'd0);
    assign byte_ph = !zero_ph && cur_reg.has_byte;
    assign end_ph  = !zero_ph && !cur_reg.has_byte;

    assign last_of_cmd = (cur_reg.nzero == 3'd1 && !cur_reg.has_byte && !cur_reg.has_end)
                      || (byte_ph && !cur_reg.has_end)
                      || end_ph;

    assign take  = valid_reg && m_tready;
    assign q_pop = !q_empty && (!valid_reg || (take && last_of_cmd));

    always_comb begin
        cur_next   = cur_reg;
        valid_next = valid_reg;
        if (q_pop) begin
            cur_next   = q_data;
            valid_next = 1'b1;
        end else if (take) begin
            // advance to the next request of this command
            if (last_of_cmd) begin
                valid_next = 1'b0;
            end else if (zero_ph) begin
                cur_next.nzero = cur_reg.nzero - 3'd1;
            end else begin
                cur_next.has_byte = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg <= cur_next;
    end

    always_comb begin
        out_byte      = byte_ph ? cur_reg.data : BYTE_ZERO;
        first_in_unit = byte_ph && cur_reg.is_hdr;
        unit_length   = end_ph ? cur_reg.len : '0;
        key_frame     = end_ph && (cur_reg.utype == TYPE_IDR);
        frame_done    = end_ph && cur_reg.done;
        if (!end_ph) begin
            param_set = PS_NONE;
        end else if (cur_reg.utype == TYPE_SPS) begin
            param_set = PS_SPS;
        end else if (cur_reg.utype == TYPE_PPS) begin
            param_set = PS_PPS;
        end else begin
            param_set = PS_NONE;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tlast  = last_of_cmd;
    assign m_tuser  = {first_in_unit, end_ph};
    assign m_tdata  = {2'b00, frame_done, param_set, key_frame, unit_length,
                       cur_reg.utype, out_byte};

endmodule
